// ===== design/vpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vpa_pkg;
    localparam int SEGMENTS     = 16;
    localparam int MEMORY_UNITS = 1024;
    localparam int IDX_W        = $clog2(SEGMENTS);
    localparam int CNT_W        = $clog2(SEGMENTS + 1);
    localparam int LEN_W        = $clog2(MEMORY_UNITS + 1);
    localparam int SIZE_W       = 11;
    localparam int ID_W         = 8;
    localparam int ADDR_W       = 10;
    localparam int STAT_W       = 3;
    localparam int CMP_W        = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOOWNER = 3'd4;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_MARK,
        OP_SPLIT,
        OP_MERGE
    } t_cell_op;

    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic [ID_W-1:0]  owner;
        logic             busy;
    } t_entry;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] k;
        logic [LEN_W-1:0] size;
        logic [ID_W-1:0]  owner;
        logic             busy;
    } t_cmd;
endpackage
`default_nettype wire

// ===== design/vpa_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vpa_cell (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [vpa_pkg::IDX_W-1:0]   i_index,
    input  vpa_pkg::t_cmd               i_cmd,
    input  vpa_pkg::t_entry             i_left,
    input  vpa_pkg::t_entry             i_right,
    output vpa_pkg::t_entry             o_entry
);
    vpa_pkg::t_entry r_entry;
    logic [vpa_pkg::IDX_W:0] w_idx;
    logic [vpa_pkg::IDX_W:0] w_k;

    assign w_idx   = {1'b0, i_index};
    assign w_k     = {1'b0, i_cmd.k};
    assign o_entry = r_entry;

    // Each cell updates itself from its own entry or a neighbor's.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.start <= '0;
            r_entry.len   <= (i_index == '0) ? vpa_pkg::LEN_W'(vpa_pkg::MEMORY_UNITS) : '0;
            r_entry.owner <= '0;
            r_entry.busy  <= 1'b0;
        end else begin
            case (i_cmd.op)
                vpa_pkg::OP_MARK: begin
                    if (w_idx == w_k) begin
                        r_entry.busy  <= i_cmd.busy;
                        r_entry.owner <= i_cmd.owner;
                    end
                end
                vpa_pkg::OP_SPLIT: begin
                    if (w_idx == w_k) begin
                        r_entry.len   <= i_cmd.size;
                        r_entry.busy  <= 1'b1;
                        r_entry.owner <= i_cmd.owner;
                    end else if (w_idx == w_k + 1'b1) begin
                        r_entry.start <= i_left.start + i_cmd.size;
                        r_entry.len   <= i_left.len - i_cmd.size;
                        r_entry.busy  <= 1'b0;
                        r_entry.owner <= '0;
                    end else if (w_idx > w_k + 1'b1) begin
                        r_entry <= i_left;
                    end
                end
                vpa_pkg::OP_MERGE: begin
                    if (w_idx + 1'b1 == w_k) begin
                        r_entry.len <= r_entry.len + i_right.len;
                    end else if (w_idx >= w_k) begin
                        r_entry <= i_right;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/variable_partition_allocator.sv =====
// Flow: a rejected beat goes straight to the response; any other item runs a scan that
// visits one segment cell per cycle, then the table update and the response.
// Throughput: one item at a time; a new beat is taken only when the previous one is done,
// and a result that is not yet taken holds the next item in its response cycle.
// Reset: synchronous, active low; the table holds one free segment over all memory,
// fit_policy is first fit, and no result is pending.
`timescale 1ns / 1ps
`default_nettype none
module variable_partition_allocator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,      // fit_policy
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,     // job_id[7:0], request_size[18:8], zero pad
    input  wire         s_axis_tuser,     // command
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata      // status[2:0], granted_address[12:3], zero pad
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_R,
        S_FREE_L,
        S_RESP
    } t_state;

    localparam int N = vpa_pkg::SEGMENTS;

    t_state                       r_state;
    logic                         r_policy;
    logic                         r_command;
    logic [vpa_pkg::ID_W-1:0]     r_id;
    logic [vpa_pkg::SIZE_W-1:0]   r_size;
    logic [vpa_pkg::CNT_W-1:0]    r_count;
    logic [vpa_pkg::IDX_W-1:0]    r_idx;
    logic [vpa_pkg::IDX_W-1:0]    r_pick;
    logic [vpa_pkg::CMP_W-1:0]    r_best;
    logic                         r_found;
    logic [vpa_pkg::LEN_W-1:0]    r_start;
    logic [vpa_pkg::STAT_W-1:0]   r_status;
    vpa_pkg::t_cmd                r_cmd;
    logic [vpa_pkg::STAT_W-1:0]   r_out_status;
    logic [vpa_pkg::ADDR_W-1:0]   r_out_addr;
    logic                         r_out_valid;

    vpa_pkg::t_entry              w_entry [N];
    vpa_pkg::t_entry              w_cur;
    vpa_pkg::t_entry              w_next;
    vpa_pkg::t_entry              w_prev;
    logic [vpa_pkg::CMP_W-1:0]    w_len;
    logic [vpa_pkg::CMP_W-1:0]    w_req;
    logic [vpa_pkg::CMP_W-1:0]    w_rem;
    logic                         w_fit;
    logic                         w_better;
    logic                         w_match;
    logic                         w_last;
    logic                         w_has_next;

    // Row of segment cells, each wired to both neighbors.
    for (genvar g = 0; g < N; g++) begin : g_cell
        vpa_pkg::t_entry w_l;
        vpa_pkg::t_entry w_r;
        if (g == 0) begin : g_l0
            assign w_l = '0;
        end else begin : g_ln
            assign w_l = w_entry[g-1];
        end
        if (g == N - 1) begin : g_rl
            assign w_r = '0;
        end else begin : g_rn
            assign w_r = w_entry[g+1];
        end
        vpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (vpa_pkg::IDX_W'(g)),
            .i_cmd   (r_cmd),
            .i_left  (w_l),
            .i_right (w_r),
            .o_entry (w_entry[g])
        );
    end

    // Scan compare on the visited cell, and neighbor reads for the merges.
    assign w_cur      = w_entry[r_idx];
    assign w_len      = vpa_pkg::CMP_W'(w_cur.len);
    assign w_req      = vpa_pkg::CMP_W'(r_size);
    assign w_rem      = w_len - w_req;
    assign w_fit      = !w_cur.busy && (w_len >= w_req);
    assign w_better   = w_fit && (!r_found || (w_rem < r_best));
    assign w_match    = w_cur.busy && (w_cur.owner == r_id);
    assign w_last     = ({1'b0, r_idx} + 1'b1) == r_count;
    assign w_has_next = ({1'b0, r_pick} + 1'b1) < r_count;
    assign w_next     = w_entry[vpa_pkg::IDX_W'({1'b0, r_pick} + 1'b1)];
    assign w_prev     = w_entry[r_pick - 1'b1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_addr, r_out_status};

    // Sequencer: state, table commands and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= 1'b0;
            r_count     <= vpa_pkg::CNT_W'(1);
            r_cmd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd.op <= vpa_pkg::OP_NOP;
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_command <= s_axis_tuser;
                        r_id      <= s_axis_tdata[7:0];
                        r_size    <= s_axis_tdata[18:8];
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_start   <= '0;
                        if (s_axis_tdata[7:0] == '0 ||
                            (!s_axis_tuser && s_axis_tdata[18:8] == '0)) begin
                            r_status <= vpa_pkg::ST_BAD;
                            r_state  <= S_RESP;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (!r_command) begin
                        if (w_better) begin
                            r_pick  <= r_idx;
                            r_best  <= w_rem;
                            r_found <= 1'b1;
                            r_start <= w_cur.start;
                        end
                        if ((w_fit && !r_policy) || w_last) begin
                            r_state <= S_RESP;
                            if (!w_better && !r_found) begin
                                r_status <= vpa_pkg::ST_NOFIT;
                                r_start  <= '0;
                            end else if ((w_better ? w_rem : r_best) == '0) begin
                                r_status    <= vpa_pkg::ST_OK;
                                r_cmd.op    <= vpa_pkg::OP_MARK;
                                r_cmd.k     <= w_better ? r_idx : r_pick;
                                r_cmd.busy  <= 1'b1;
                                r_cmd.owner <= r_id;
                            end else if (r_count >= vpa_pkg::CNT_W'(N)) begin
                                r_status <= vpa_pkg::ST_FULL;
                                r_start  <= '0;
                            end else begin
                                r_status    <= vpa_pkg::ST_OK;
                                r_cmd.op    <= vpa_pkg::OP_SPLIT;
                                r_cmd.k     <= w_better ? r_idx : r_pick;
                                r_cmd.size  <= vpa_pkg::LEN_W'(r_size);
                                r_cmd.owner <= r_id;
                                r_count     <= r_count + 1'b1;
                            end
                        end
                    end else begin
                        if (w_match) begin
                            r_pick      <= r_idx;
                            r_status    <= vpa_pkg::ST_OK;
                            r_cmd.op    <= vpa_pkg::OP_MARK;
                            r_cmd.k     <= r_idx;
                            r_cmd.busy  <= 1'b0;
                            r_cmd.owner <= '0;
                            r_state     <= S_FREE_R;
                        end else if (w_last) begin
                            r_status <= vpa_pkg::ST_NOOWNER;
                            r_state  <= S_RESP;
                        end
                    end
                end
                S_FREE_R: begin
                    // Merge the free right neighbor into the released segment.
                    if (w_has_next && !w_next.busy) begin
                        r_cmd.op <= vpa_pkg::OP_MERGE;
                        r_cmd.k  <= r_pick + 1'b1;
                        r_count  <= r_count - 1'b1;
                    end
                    r_state <= S_FREE_L;
                end
                S_FREE_L: begin
                    // Merge the released segment into a free left neighbor.
                    if (r_pick != '0 && !w_prev.busy) begin
                        r_cmd.op <= vpa_pkg::OP_MERGE;
                        r_cmd.k  <= r_pick;
                        r_count  <= r_count - 1'b1;
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_addr   <= (r_status == vpa_pkg::ST_OK && !r_command) ?
                                        vpa_pkg::ADDR_W'(r_start) : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= vpa_pkg::CNT_W'(1) && r_count <= vpa_pkg::CNT_W'(N))
        else $error("segment count out of range");
    a_first_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry[0].start == '0)
        else $error("first segment does not start at zero");
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");
    a_split_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.op == vpa_pkg::OP_SPLIT |-> r_count >= vpa_pkg::CNT_W'(2))
        else $error("split issued without room");
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum bit {CMD_ALLOC = 1'b0, CMD_FREE = 1'b1} t_command;

    // Same layout as the low bits of the result beat: status lowest.
    typedef struct packed {
        logic [vpa_pkg::ADDR_W-1:0] addr;
        logic [vpa_pkg::STAT_W-1:0] status;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // job_id[7:0], request_size[18:8], zero pad
    logic        s_axis_tuser = 1'b0; // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // status[2:0], granted_address[12:3], zero pad

    variable_partition_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the segment table.
    int unsigned seg_start [vpa_pkg::SEGMENTS];
    int unsigned seg_len   [vpa_pkg::SEGMENTS];
    int unsigned seg_owner [vpa_pkg::SEGMENTS];
    bit          seg_busy  [vpa_pkg::SEGMENTS];
    int unsigned seg_count;
    bit          smallest_gap;

    t_answer answers_due[$];
    int      error_count = 0;
    int      answer_count = 0;
    int      ok_allocs = 0;
    int      full_hits = 0;
    int      cycle_count = 0;
    bit      sink_idles = 1'b1;
    bit      source_idles = 1'b1;
    bit      hold_sink = 1'b0;

    task automatic report(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic void table_reset();
        for (int i = 0; i < vpa_pkg::SEGMENTS; i++) begin
            seg_start[i] = 0;
            seg_len[i] = 0;
            seg_owner[i] = 0;
            seg_busy[i] = 0;
        end
        seg_len[0] = vpa_pkg::MEMORY_UNITS;
        seg_count = 1;
    endfunction

    function automatic void drop_segment(int unsigned k);
        for (int unsigned j = k; j + 1 < seg_count; j++) begin
            seg_start[j] = seg_start[j+1];
            seg_len[j] = seg_len[j+1];
            seg_owner[j] = seg_owner[j+1];
            seg_busy[j] = seg_busy[j+1];
        end
        seg_start[seg_count-1] = 0;
        seg_len[seg_count-1] = 0;
        seg_owner[seg_count-1] = 0;
        seg_busy[seg_count-1] = 0;
        seg_count--;
    endfunction

    // Applies one request to the shadow table and returns the answer.
    function automatic t_answer allocator_answer(t_command cmd, int unsigned id,
                                                 int unsigned size);
        t_answer a;
        int unsigned pick, rem, i;
        bit found;
        a = '{status: vpa_pkg::ST_OK, addr: '0};
        pick = 0;
        rem = 0;
        found = 0;
        if (id == 0 || (cmd == CMD_ALLOC && size == 0)) begin
            a.status = vpa_pkg::ST_BAD;
            return a;
        end
        if (cmd == CMD_ALLOC) begin
            for (i = 0; i < seg_count; i++) begin
                if (!seg_busy[i] && seg_len[i] >= size &&
                    (!found || seg_len[i] - size < rem)) begin
                    pick = i;
                    rem = seg_len[i] - size;
                    found = 1;
                    if (!smallest_gap) break;
                end
            end
            if (!found) begin
                a.status = vpa_pkg::ST_NOFIT;
                return a;
            end
            if (rem != 0 && seg_count >= vpa_pkg::SEGMENTS) begin
                a.status = vpa_pkg::ST_FULL;
                full_hits++;
                return a;
            end
            if (rem != 0) begin
                for (i = seg_count; i > pick; i--) begin
                    seg_start[i] = seg_start[i-1];
                    seg_len[i] = seg_len[i-1];
                    seg_owner[i] = seg_owner[i-1];
                    seg_busy[i] = seg_busy[i-1];
                end
                seg_len[pick] = size;
                seg_start[pick+1] = seg_start[pick] + size;
                seg_len[pick+1] = rem;
                seg_busy[pick+1] = 0;
                seg_owner[pick+1] = 0;
                seg_count++;
            end
            seg_busy[pick] = 1;
            seg_owner[pick] = id;
            a.addr = seg_start[pick][vpa_pkg::ADDR_W-1:0];
            ok_allocs++;
            return a;
        end
        for (i = 0; i < seg_count; i++)
            if (seg_busy[i] && seg_owner[i] == id) break;
        if (i >= seg_count) begin
            a.status = vpa_pkg::ST_NOOWNER;
            return a;
        end
        seg_busy[i] = 0;
        seg_owner[i] = 0;
        if (i + 1 < seg_count && !seg_busy[i+1]) begin
            seg_len[i] += seg_len[i+1];
            drop_segment(i + 1);
        end
        if (i > 0 && !seg_busy[i-1]) begin
            seg_len[i-1] += seg_len[i];
            drop_segment(i);
        end
        return a;
    endfunction

    // Sends one request beat and records its expected answer.
    task automatic send_request(t_command cmd, int unsigned id, int unsigned size);
        @(posedge i_clk);
        if (source_idles)
            while ($urandom_range(99) < 33) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {5'd0, size[vpa_pkg::SIZE_W-1:0], id[vpa_pkg::ID_W-1:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        answers_due.push_back(allocator_answer(cmd, id, size));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic set_policy(bit policy);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (vpa_pkg::SEGMENTS + 6) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= policy;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        smallest_gap = policy;
    endtask

    // Ready pattern for the result side.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: errors");
            $finish;
        end
        m_axis_tready <= !hold_sink && (!sink_idles || $urandom_range(99) >= 33);
    end

    // Checks each answer beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[12:0];
            answer_count++;
            if (answers_due.size() == 0) begin
                report($sformatf("unexpected answer %h", m_axis_tdata));
            end else begin
                want = answers_due.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.addr !== want.addr)
                    report($sformatf("address %0d, want %0d", got.addr, want.addr));
            end
        end
    end

    task automatic test_directed();
        send_request(CMD_ALLOC, 0, 10);
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_ALLOC, 5, 0);
        send_request(CMD_ALLOC, 5, 2047);
        send_request(CMD_ALLOC, 5, 1025);
        send_request(CMD_FREE, 9, 0);
        send_request(CMD_ALLOC, 255, 1024);
        send_request(CMD_ALLOC, 7, 1);
        send_request(CMD_FREE, 255, 1234);
        // Fill the table with small pieces to reach the full case.
        for (int i = 1; i <= 16; i++) send_request(CMD_ALLOC, i, i);
        send_request(CMD_ALLOC, 1, 5);
        send_request(CMD_FREE, 3, 0);
        send_request(CMD_FREE, 2, 0);
        send_request(CMD_FREE, 4, 0);
        send_request(CMD_ALLOC, 3, 9);
        send_request(CMD_ALLOC, 3, 20);
        send_request(CMD_FREE, 3, 0);
    endtask

    // Mostly valid churn: allocations and frees, mostly by ids 1 to 24.
    task automatic test_random(int count, bit policy);
        int unsigned id, size, pick;
        set_policy(policy);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            id = (pick < 3) ? 0 : $urandom_range(1, 255);
            if (pick < 50) begin
                id = (pick < 45) ? $urandom_range(1, 24) : id;
                size = (pick < 6) ? $urandom_range(0, 2047) : $urandom_range(1, 200);
                send_request(CMD_ALLOC, id, size);
            end else begin
                send_request(CMD_FREE, (pick < 95) ? $urandom_range(1, 24) : id,
                             $urandom_range(0, 2047));
            end
        end
    endtask

    // Stalls the result side long enough that the input side backs up.
    task automatic test_backpressure();
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int n = 0; n < 20; n++)
                send_request(CMD_ALLOC, $urandom_range(1, 255), $urandom_range(1, 64));
        join
    endtask

    initial begin
        table_reset();
        smallest_gap = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_policy(1'b1);
        test_directed();
        test_random(250, 1'b0);
        test_random(250, 1'b1);
        sink_idles = 1'b0;
        source_idles = 1'b0;
        test_random(150, 1'b0);
        sink_idles = 1'b1;
        source_idles = 1'b1;
        test_backpressure();
        test_random(200, 1'b1);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (vpa_pkg::SEGMENTS + 10) @(posedge i_clk);
        $display("covered %0d answers under both fit policies: %0d grants, %0d table-full",
                 answer_count, ok_allocs, full_hits);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
